// ----- src/lpab_pkg.sv -----
package lpab_pkg;

   localparam int LPAB_POINTS = 360;

   localparam logic [1:0] MODE_BYTE = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_POP  = 2'd2;

   localparam logic [7:0] HDR0 = 8'h54;
   localparam logic [7:0] HDR1 = 8'h2C;

   // parser positions
   localparam logic [5:0] PH_HUNT      = 6'd0;
   localparam logic [5:0] PH_HDR0_SEEN = 6'd1;
   localparam logic [5:0] PH_HDR1_SEEN = 6'd2;
   localparam logic [5:0] PH_START_LO  = 6'd4;
   localparam logic [5:0] PH_START_HI  = 6'd5;
   localparam logic [5:0] PH_SAMP_FIRST = 6'd6;
   localparam logic [5:0] PH_SAMP_LAST = 6'd41;
   localparam logic [5:0] PH_END_LO    = 6'd42;
   localparam logic [5:0] PH_END_HI    = 6'd43;
   localparam logic [5:0] PH_LAST      = 6'd46;

   localparam int NSAMP = 12;
   localparam int SW    = 4;

   localparam int ACC_W = 21;
   localparam int X_W   = 20;
   localparam int PROD_W = 40;
   localparam int Q_W   = 13;
   localparam int RECIP_SHIFT = 30;

   localparam logic [16:0]      HALF_TURN_EXT = 17'd36000;
   localparam logic [ACC_W-1:0] TURN_FINE     = 21'd396000;
   localparam logic [ACC_W-1:0] HALF_DEG_FINE = 21'd550;
   // ceil(2^30 / 1100), exact for dividends below 2^20
   localparam logic [X_W-1:0]   RECIP_1100    = 20'd976129;

   localparam int LPAB_QDEPTH = 2;

   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_READ,
      KIND_POP,
      KIND_PACKET
   } lpab_kind_type;

   typedef struct packed {
      lpab_kind_type             kind;
      logic [8:0]                bin_index;
      logic [15:0]               open_angle;
      logic [15:0]               close_angle;
      logic [NSAMP-1:0][15:0]    samples;
   } lpab_cmd_type;

   typedef struct packed {
      logic [4:0]  pad;
      logic [31:0] revolution_count;
      logic        ready_flag;
      logic [15:0] distance;
      logic        sweep_done;
      logic        packet_done;
   } lpab_rsp_type;

endpackage

// ----- src/lpab_ram.sv -----
module lpab_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 360
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/lpab_front.sv -----
module lpab_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [lpab_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [lpab_pkg::REQ_USER_W-1:0]     req_tuser,
   input  logic                                clear_done,
   input  logic                                fifo_full,
   output logic                                push,
   output lpab_pkg::lpab_cmd_type              push_cmd
);

   import lpab_pkg::*;

   logic [5:0]              phase_ff, phase_in;
   logic [15:0]             start_ff, start_in;
   logic [15:0]             end_ff, end_in;
   logic [NSAMP-1:0][15:0]  samples_ff, samples_in;
   logic [SW-1:0]           samp_k_ff, samp_k_in;
   logic [1:0]              samp_r_ff, samp_r_in;

   logic       accept;
   logic [7:0] rx_byte;
   logic [8:0] bin_index;
   logic [1:0] mode;

   assign req_tready = clear_done && !fifo_full;
   assign accept     = req_tvalid && req_tready;
   assign mode       = req_tuser[1:0];
   assign rx_byte    = req_tdata[7:0];
   assign bin_index  = req_tdata[16:8];
   assign push       = accept;

   always_comb begin
      phase_in   = phase_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      samples_in = samples_ff;
      samp_k_in  = samp_k_ff;
      samp_r_in  = samp_r_ff;

      push_cmd.kind        = KIND_NONE;
      push_cmd.bin_index   = bin_index;
      push_cmd.open_angle  = start_ff;
      push_cmd.close_angle = end_ff;
      push_cmd.samples     = samples_ff;

      case (mode)
         MODE_BYTE: begin
            if (accept) begin
               if (phase_ff == PH_HUNT) begin
                  phase_in = (rx_byte == HDR0) ? PH_HDR0_SEEN : PH_HUNT;
               end else if (phase_ff == PH_HDR0_SEEN) begin
                  if (rx_byte == HDR1) begin
                     phase_in = PH_HDR1_SEEN;
                  end else begin
                     phase_in = (rx_byte == HDR0) ? PH_HDR0_SEEN : PH_HUNT;
                  end
               end else begin
                  if (phase_ff == PH_START_LO) begin
                     start_in = {8'd0, rx_byte};
                  end else if (phase_ff == PH_START_HI) begin
                     start_in  = {rx_byte, start_ff[7:0]};
                     samp_k_in = '0;
                     samp_r_in = 2'd0;
                  end else if (phase_ff >= PH_SAMP_FIRST && phase_ff <= PH_SAMP_LAST) begin
                     // three bytes per sample, third byte is intensity
                     if (samp_r_ff == 2'd0) begin
                        samples_in[samp_k_ff] = {8'd0, rx_byte};
                     end else if (samp_r_ff == 2'd1) begin
                        samples_in[samp_k_ff][15:8] = rx_byte;
                     end
                     if (samp_r_ff == 2'd2) begin
                        samp_r_in = 2'd0;
                        samp_k_in = samp_k_ff + 1'b1;
                     end else begin
                        samp_r_in = samp_r_ff + 1'b1;
                     end
                  end else if (phase_ff == PH_END_LO) begin
                     end_in = {8'd0, rx_byte};
                  end else if (phase_ff == PH_END_HI) begin
                     end_in = {rx_byte, end_ff[7:0]};
                  end
                  if (phase_ff >= PH_LAST) begin
                     phase_in      = PH_HUNT;
                     push_cmd.kind = KIND_PACKET;
                  end else begin
                     phase_in = phase_ff + 1'b1;
                  end
               end
            end
         end
         MODE_READ: begin
            push_cmd.kind = KIND_READ;
         end
         MODE_POP: begin
            push_cmd.kind = KIND_POP;
         end
         default: begin
            push_cmd.kind = KIND_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff   <= start_in;
      end_ff     <= end_in;
      samples_ff <= samples_in;
      samp_k_ff  <= samp_k_in;
      samp_r_ff  <= samp_r_in;
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- src/lpab_fifo.sv -----
module lpab_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lpab_pkg::lpab_cmd_type push_cmd,
   output logic                   full,
   input  logic                   pop,
   output lpab_pkg::lpab_cmd_type head_cmd,
   output logic                   head_valid
);

   import lpab_pkg::*;

   localparam int DEPTH = LPAB_QDEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   lpab_cmd_type    entries_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/lpab_back.sv -----
module lpab_back #(
   parameter int POINTS = lpab_pkg::LPAB_POINTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lpab_pkg::lpab_cmd_type head_cmd,
   input  logic                   head_valid,
   output logic                   pop,
   output logic                   clear_done,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output lpab_pkg::lpab_rsp_type rsp_data
);

   import lpab_pkg::*;

   localparam int AW = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam logic [Q_W-1:0] POINTS_Q = Q_W'(POINTS);
   localparam logic [AW-1:0]  LAST_ADDR = AW'(POINTS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_WAIT,
      ST_RD_DONE,
      ST_FOLD,
      ST_MUL,
      ST_QUOT,
      ST_WRAP,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic                    ready_ff, ready_in;
   logic [31:0]             count_ff, count_in;
   logic [15:0]             prev_end_ff, prev_end_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lpab_rsp_type            rsp_data_ff, rsp_data_in;

   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic                    rd_hit_ff, rd_hit_in;
   logic [15:0]             end_ff, end_in;
   logic [15:0]             diff_ff, diff_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [X_W-1:0]          x_ff, x_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic [NSAMP-1:0][15:0]  samp_ff, samp_in;
   logic [SW-1:0]           si_ff, si_in;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [15:0]             wr_data;
   logic [15:0]             rd_data;

   logic                    out_free;
   lpab_rsp_type            base_rsp;
   logic [16:0]             end_ext;
   logic [ACC_W-1:0]        folded;
   logic                    sweep;

   lpab_ram #(
      .WIDTH (16),
      .DEPTH (POINTS)
   ) u_range_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign clear_done = (state_ff != ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      base_rsp                  = '0;
      base_rsp.ready_flag       = ready_ff;
      base_rsp.revolution_count = count_ff;

      end_ext = (head_cmd.close_angle < head_cmd.open_angle)
              ? {1'b0, head_cmd.close_angle} + HALF_TURN_EXT
              : {1'b0, head_cmd.close_angle};
      folded  = (acc_ff >= TURN_FINE) ? acc_ff - TURN_FINE : acc_ff;
      sweep   = (end_ff < prev_end_ff) && (prev_end_ff != 16'd0);

      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      ready_in     = ready_ff;
      count_in     = count_ff;
      prev_end_in  = prev_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rd_addr_in   = rd_addr_ff;
      rd_hit_in    = rd_hit_ff;
      end_in       = end_ff;
      diff_in      = diff_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      samp_in      = samp_ff;
      si_in        = si_ff;
      pop          = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = 16'd0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid && out_free) begin
               pop = 1'b1;
               case (head_cmd.kind)
                  KIND_READ: begin
                     rd_addr_in = AW'(head_cmd.bin_index);
                     rd_hit_in  = ({4'd0, head_cmd.bin_index} < POINTS_Q);
                     state_in   = ST_RD_WAIT;
                  end
                  KIND_POP: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = base_rsp;
                     ready_in     = 1'b0;
                  end
                  KIND_PACKET: begin
                     end_in   = head_cmd.close_angle;
                     diff_in  = 16'(end_ext - {1'b0, head_cmd.open_angle});
                     acc_in   = ACC_W'(head_cmd.open_angle) * ACC_W'(11);
                     samp_in  = head_cmd.samples;
                     si_in    = '0;
                     state_in = ST_FOLD;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = base_rsp;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            state_in = ST_RD_DONE;
         end
         ST_RD_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = base_rsp;
               rsp_data_in.distance = rd_hit_ff ? rd_data : 16'd0;
               state_in             = ST_IDLE;
            end
         end
         ST_FOLD: begin
            // one turn folded back, then half a degree for rounding
            x_in     = X_W'(folded + HALF_DEG_FINE);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(x_ff) * PROD_W'(RECIP_1100);
            state_in = ST_QUOT;
         end
         ST_QUOT: begin
            q_in     = Q_W'(prod_ff[PROD_W-1:RECIP_SHIFT]);
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (q_ff >= POINTS_Q) begin
               q_in = q_ff - POINTS_Q;
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(q_ff);
               wr_data = samp_ff[si_ff];
               acc_in  = acc_ff + ACC_W'(diff_ff);
               if (si_ff == SW'(NSAMP - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  si_in    = si_ff + 1'b1;
                  state_in = ST_FOLD;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = base_rsp;
               rsp_data_in.packet_done = 1'b1;
               rsp_data_in.sweep_done  = sweep;
               if (sweep) begin
                  count_in                     = count_ff + 1'b1;
                  ready_in                     = 1'b1;
                  rsp_data_in.revolution_count = count_ff + 1'b1;
               end
               prev_end_in = end_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rd_addr_ff  <= rd_addr_in;
      rd_hit_ff   <= rd_hit_in;
      end_ff      <= end_in;
      diff_ff     <= diff_in;
      acc_ff      <= acc_in;
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      q_ff        <= q_in;
      samp_ff     <= samp_in;
      si_ff       <= si_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         ready_ff     <= 1'b0;
         count_ff     <= '0;
         prev_end_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         ready_ff     <= ready_in;
         count_ff     <= count_in;
         prev_end_ff  <= prev_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ----- src/lidar_packet_angle_binner_unit.sv -----
// channel  direction  tdata fields (low bit up)                        tuser
// req      in         rx_byte[7:0] bin_index[16:8] zero[23:17]        mode[1:0]
// rsp      out        packet_done[0] sweep_done[1] distance[17:2]     -
//                     ready_flag[18] revolution_count[50:19] zero[55:51]
//
// after reset the range memory is zeroed one bin a cycle, all POINTS bins with req_tready low
// byte, pop, idle items: answered in IDLE; bin read: via RD_WAIT, RD_DONE (memory read port)
// packet end: 12 samples each pass FOLD, MUL, QUOT, WRAP of the shared divide-and-wrap unit
// a two-entry request queue takes up to two more requests while a packet is binned
// the rsp register holds a result under stall while the next request is already queued
module lidar_packet_angle_binner_unit #(
   parameter int POINTS = lpab_pkg::LPAB_POINTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lpab_pkg::REQ_DATA_W-1:0]  req_tdata,  // rx_byte, bin_index
   input  logic [lpab_pkg::REQ_USER_W-1:0]  req_tuser,  // mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lpab_pkg::RSP_DATA_W-1:0]  rsp_tdata   // packet_done, sweep_done, distance,
                                                        // ready_flag, revolution_count
);

   import lpab_pkg::*;

   logic          clear_done;
   logic          fifo_full;
   logic          push;
   lpab_cmd_type  push_cmd;
   logic          pop;
   lpab_cmd_type  head_cmd;
   logic          head_valid;
   lpab_rsp_type  rsp_data;

   lpab_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clear_done (clear_done),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   lpab_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (fifo_full),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   lpab_back #(
      .POINTS (POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data;

`ifndef SYNTH
   a_no_req_during_clear: assert property (@(posedge clock) disable iff (reset)
      !clear_done |-> !req_tready)
      else $error("request taken while range memory is being cleared");

   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !push)
      else $error("request queue overflow");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("request queue popped while empty");

   a_sweep_needs_packet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("sweep_done without packet_done");
`endif

endmodule

// ----- verif/lidar_packet_angle_binner_unit_tb.sv -----
module lidar_packet_angle_binner_unit_tb;
   import lpab_pkg::*;

   localparam logic [1:0]  MODE_NONE         = 2'd3;
   localparam logic [31:0] FINE_PER_CENTIDEG = 32'd11;
   localparam logic [31:0] FINE_PER_DEG      = 32'd1100;
   localparam logic [31:0] BIN_COUNT         = LPAB_POINTS;
   localparam int          CENTIDEG_TURN     = 36000;
   localparam int          FRAME_BYTES       = PH_LAST + 1;
   localparam int          PROBE_ROWS        = 16;
   localparam int          TOTAL_REQUESTS    = 1250;
   localparam int          PHASE_REQUESTS    = 420;
   localparam int          HOLD_CYCLES       = 400;
   localparam int          DRAIN_CYCLES      = 200;
   localparam int          WATCHDOG_LIMIT    = 5000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  rx;
      logic [8:0]  idx;
      logic        typed;
      logic [15:0] distance;
      logic        ready;
      logic [31:0] count;
   } probe_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;  // rx_byte[7:0] bin_index[16:8] zero[23:17]
   logic [REQ_USER_W-1:0] req_tuser;  // mode[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // packet_done[0] sweep_done[1] distance[17:2]
                                      // ready_flag[18] revolution_count[50:19] zero[55:51]

   // predictor state
   logic [5:0]  parser_pos;
   logic [15:0] open_angle;
   logic [15:0] close_angle;
   logic [15:0] dist_buf [NSAMP];
   logic [15:0] bin_mem [LPAB_POINTS];
   logic [15:0] prev_close_angle;
   logic [31:0] rev_count;
   logic        sweep_flag;

   lpab_rsp_type  binner_results_due [$];
   probe_row_type probe_table [PROBE_ROWS];

   int req_idle_pct = 28;
   int rsp_idle_pct = 84;
   bit hold_request = 1'b0;
   int holds_done = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int mismatch_count = 0;
   int packets_binned = 0;
   int revolutions_seen = 0;
   int reads_done = 0;
   int pops_taken = 0;
   int stall_cycles = 0;
   int scan_angle = 0;

   lidar_packet_angle_binner_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic lpab_rsp_type predict_binner_result(input logic [1:0] mode,
                                                          input logic [7:0] rx,
                                                          input logic [8:0] idx);
      lpab_rsp_type res;
      logic [31:0]  s32, e32, ext, diff, fine, bin, lane;
      int           off;
      res = '0;
      res.ready_flag = sweep_flag;
      case (mode)
         MODE_BYTE: begin
            if (parser_pos == PH_HUNT) begin
               parser_pos = (rx == HDR0) ? PH_HDR0_SEEN : PH_HUNT;
            end else if (parser_pos == PH_HDR0_SEEN) begin
               if (rx == HDR1)
                  parser_pos = PH_HDR1_SEEN;
               else
                  parser_pos = (rx == HDR0) ? PH_HDR0_SEEN : PH_HUNT;
            end else begin
               if (parser_pos == PH_START_LO) begin
                  open_angle = {8'h00, rx};
               end else if (parser_pos == PH_START_HI) begin
                  open_angle[15:8] = rx;
               end else if (parser_pos >= PH_SAMP_FIRST && parser_pos <= PH_SAMP_LAST) begin
                  off = int'(parser_pos - PH_SAMP_FIRST);
                  // third byte of a sample is intensity, dropped
                  if (off % 3 == 0)
                     dist_buf[off / 3] = {8'h00, rx};
                  else if (off % 3 == 1)
                     dist_buf[off / 3][15:8] = rx;
               end else if (parser_pos == PH_END_LO) begin
                  close_angle = {8'h00, rx};
               end else if (parser_pos == PH_END_HI) begin
                  close_angle[15:8] = rx;
               end
               if (parser_pos == PH_LAST) begin
                  s32 = 32'(open_angle);
                  e32 = 32'(close_angle);
                  ext = (e32 < s32) ? e32 + HALF_TURN_EXT : e32;
                  diff = ext - s32;
                  // 32-bit wrap on purpose, a single turn is folded out
                  for (lane = 0; lane < NSAMP; lane++) begin
                     fine = FINE_PER_CENTIDEG * s32 + lane * diff;
                     if (fine >= TURN_FINE)
                        fine = fine - TURN_FINE;
                     bin = ((fine + HALF_DEG_FINE) / FINE_PER_DEG) % BIN_COUNT;
                     bin_mem[bin] = dist_buf[lane];
                  end
                  if (close_angle < prev_close_angle && prev_close_angle != 16'd0) begin
                     rev_count = rev_count + 32'd1;
                     sweep_flag = 1'b1;
                     res.sweep_done = 1'b1;
                     revolutions_seen++;
                  end
                  prev_close_angle = close_angle;
                  res.packet_done = 1'b1;
                  packets_binned++;
                  parser_pos = PH_HUNT;
               end else begin
                  parser_pos = parser_pos + 6'd1;
               end
            end
         end
         MODE_READ: begin
            reads_done++;
            if (idx < LPAB_POINTS)
               res.distance = bin_mem[idx];
         end
         MODE_POP: begin
            if (sweep_flag)
               pops_taken++;
            sweep_flag = 1'b0;
         end
         default: ;
      endcase
      res.revolution_count = rev_count;
      return res;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch at response %0d: %s is 0x%0h, expected 0x%0h",
               responses_seen, field, got, want);
   endtask

   // entered and left at a falling edge
   task automatic push_request(input logic [1:0] mode, input logic [7:0] rx,
                               input logic [8:0] idx, input bit typed,
                               input lpab_rsp_type typed_rsp);
      lpab_rsp_type predicted;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {7'd0, idx, rx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = predict_binner_result(mode, rx, idx);
      binner_results_due.push_back(typed ? typed_rsp : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic offer(input logic [1:0] mode, input logic [7:0] rx, input logic [8:0] idx);
      push_request(mode, rx, idx, 1'b0, '0);
   endtask

   task automatic offer_side_request();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12)
         offer(MODE_READ, 8'($urandom_range(0, 255)),
               ($urandom_range(0, 6) == 0) ? 9'($urandom_range(360, 511))
                                           : 9'($urandom_range(0, 359)));
      else if (pick < 19)
         offer(MODE_POP, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
      else
         offer(MODE_NONE, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
   endtask

   task automatic send_packet();
      logic [7:0]  frame [FRAME_BYTES];
      logic [15:0] pkt_start, pkt_end, sample_mm;
      int          length;
      frame[0] = HDR0;
      frame[1] = HDR1;
      frame[2] = 8'($urandom_range(0, 255));
      frame[3] = 8'($urandom_range(0, 255));
      // header pattern inside the body must not resync the parser
      if ($urandom_range(0, 3) == 0) begin
         frame[2] = HDR0;
         frame[3] = HDR1;
      end
      case ($urandom_range(0, 9))
         0: begin
            pkt_start = 16'($urandom_range(0, 65535));
            pkt_end   = 16'($urandom_range(0, 65535));
         end
         1: begin
            pkt_start = 16'(CENTIDEG_TURN - $urandom_range(1, 500));
            pkt_end   = 16'($urandom_range(0, 500));
         end
         default: begin
            pkt_start  = 16'(scan_angle);
            pkt_end    = 16'((scan_angle + $urandom_range(0, 3000)) % CENTIDEG_TURN);
            scan_angle = (pkt_end + $urandom_range(0, 5000)) % CENTIDEG_TURN;
         end
      endcase
      frame[4] = pkt_start[7:0];
      frame[5] = pkt_start[15:8];
      for (int s = 0; s < NSAMP; s++) begin
         case ($urandom_range(0, 19))
            0: sample_mm = 16'hFFFF;
            1: sample_mm = 16'h0000;
            default: sample_mm = 16'($urandom_range(0, 65535));
         endcase
         frame[PH_SAMP_FIRST + 3 * s]     = sample_mm[7:0];
         frame[PH_SAMP_FIRST + 3 * s + 1] = sample_mm[15:8];
         frame[PH_SAMP_FIRST + 3 * s + 2] = 8'($urandom_range(0, 255));
      end
      frame[PH_END_LO] = pkt_end[7:0];
      frame[PH_END_HI] = pkt_end[15:8];
      for (int j = PH_END_HI + 1; j < FRAME_BYTES; j++)
         frame[j] = 8'($urandom_range(0, 255));
      // now and then a cut-off packet
      length = ($urandom_range(0, 14) == 0) ? $urandom_range(3, FRAME_BYTES - 1) : FRAME_BYTES;
      for (int j = 0; j < length; j++) begin
         if ($urandom_range(0, 99) < 6)
            offer_side_request();
         offer(MODE_BYTE, frame[j], 9'($urandom_range(0, 511)));
      end
   endtask

   always @(posedge clock) begin
      lpab_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = lpab_rsp_type'(rsp_tdata);
         if (binner_results_due.size() == 0) begin
            report_mismatch("unexpected response, count", got.revolution_count, 32'd0);
         end else begin
            want = binner_results_due.pop_front();
            if (got.packet_done !== want.packet_done)
               report_mismatch("packet_done", 32'(got.packet_done), 32'(want.packet_done));
            if (got.sweep_done !== want.sweep_done)
               report_mismatch("sweep_done", 32'(got.sweep_done), 32'(want.sweep_done));
            if (got.distance !== want.distance)
               report_mismatch("distance", 32'(got.distance), 32'(want.distance));
            if (got.ready_flag !== want.ready_flag)
               report_mismatch("ready_flag", 32'(got.ready_flag), 32'(want.ready_flag));
            if (got.revolution_count !== want.revolution_count)
               report_mismatch("revolution_count", got.revolution_count, want.revolution_count);
            if (got.pad !== want.pad)
               report_mismatch("zero fill", 32'(got.pad), 32'(want.pad));
         end
         responses_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("no progress for %0d cycles, %0d responses outstanding",
                     stall_cycles, binner_results_due.size());
            $display("lidar_packet_angle_binner_unit_tb failed");
            $finish;
         end
      end
   end

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         // long back-pressure so the request queue fills and the input stalls
         if (hold_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            holds_done++;
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   initial begin
      lpab_rsp_type typed_rsp;
      logic [7:0]   noise;
      int           pick;
      int           idle_phase;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      parser_pos       = PH_HUNT;
      open_angle       = '0;
      close_angle      = '0;
      prev_close_angle = '0;
      rev_count        = '0;
      sweep_flag       = 1'b0;
      idle_phase       = 0;
      for (int i = 0; i < NSAMP; i++)
         dist_buf[i] = '0;
      for (int i = 0; i < LPAB_POINTS; i++)
         bin_mem[i] = '0;

      //                mode       rx     idx     typed dist   rdy   count
      probe_table[0]  = '{MODE_READ, 8'h00, 9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[1]  = '{MODE_READ, 8'hFF, 9'd359, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[2]  = '{MODE_READ, 8'h00, 9'd360, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[3]  = '{MODE_READ, 8'h00, 9'd511, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[4]  = '{MODE_POP,  8'h00, 9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[5]  = '{MODE_NONE, 8'hFF, 9'd511, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[6]  = '{MODE_BYTE, 8'h00, 9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[7]  = '{MODE_BYTE, 8'hFF, 9'd511, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[8]  = '{MODE_BYTE, HDR1,  9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[9]  = '{MODE_BYTE, HDR0,  9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[10] = '{MODE_BYTE, HDR0,  9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[11] = '{MODE_READ, 8'h00, 9'd5,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[12] = '{MODE_BYTE, 8'h00, 9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[13] = '{MODE_BYTE, HDR0,  9'd0,   1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[14] = '{MODE_POP,  8'hFF, 9'd511, 1'b1, 16'd0, 1'b0, 32'd0};
      probe_table[15] = '{MODE_BYTE, 8'h55, 9'd0,   1'b1, 16'd0, 1'b0, 32'd0};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < PROBE_ROWS; r++) begin
         typed_rsp = '0;
         typed_rsp.distance         = probe_table[r].distance;
         typed_rsp.ready_flag       = probe_table[r].ready;
         typed_rsp.revolution_count = probe_table[r].count;
         push_request(probe_table[r].mode, probe_table[r].rx, probe_table[r].idx,
                      probe_table[r].typed, typed_rsp);
      end

      while (requests_sent < TOTAL_REQUESTS) begin
         if (idle_phase == 0 && requests_sent >= PHASE_REQUESTS) begin
            idle_phase   = 1;
            req_idle_pct = 84;
            rsp_idle_pct = 28;
         end else if (idle_phase == 1 && requests_sent >= 2 * PHASE_REQUESTS) begin
            idle_phase   = 2;
            req_idle_pct = 0;
            rsp_idle_pct = 0;
            hold_request = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick < 15) begin
            send_packet();
         end else if (pick < 17) begin
            repeat ($urandom_range(1, 4)) begin
               noise = 8'($urandom_range(0, 255));
               if (noise == HDR0)
                  noise = 8'h00;
               offer(MODE_BYTE, noise, 9'($urandom_range(0, 511)));
            end
         end else if (pick < 18) begin
            noise = 8'($urandom_range(0, 255));
            if (noise == HDR0 || noise == HDR1)
               noise = 8'hA5;
            offer(MODE_BYTE, HDR0, 9'($urandom_range(0, 511)));
            offer(MODE_BYTE, noise, 9'($urandom_range(0, 511)));
         end else begin
            repeat ($urandom_range(1, 4)) offer_side_request();
         end
      end
      req_tvalid <= 1'b0;

      while (binner_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d requests: %0d packets binned, %0d revolutions, %0d bin reads,",
               requests_sent, packets_binned, revolutions_seen, reads_done);
      $display("%0d pops that cleared the ready flag, %0d long output stalls, %0d mismatches",
               pops_taken, holds_done, mismatch_count);
      if (mismatch_count == 0)
         $display("lidar_packet_angle_binner_unit_tb passed");
      else
         $display("lidar_packet_angle_binner_unit_tb failed");
      $finish;
   end

endmodule
